// ----- src/lbpg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lbpg_pkg;

  localparam int NUM_BUTTONS  = 3;
  localparam int TIMER_BITS   = 16;
  localparam int REG_BITS     = 16;
  localparam int NUM_REGS     = 7;
  localparam int REG_IDX_BITS = 3;
  localparam int LAMP_BITS    = 3;
  localparam int CMP_BITS     = (TIMER_BITS > REG_BITS) ? TIMER_BITS : REG_BITS;

  typedef logic [TIMER_BITS-1:0]   timer_t;
  typedef logic [REG_BITS-1:0]     reg_t;
  typedef logic [LAMP_BITS-1:0]    lamps_t;

  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_SET_BUTTON = 2'd1,
    OP_SET_TOWER  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    MODE_OFF    = 3'd0,
    MODE_ON     = 3'd1,
    MODE_SLOW   = 3'd2,
    MODE_FAST   = 3'd3,
    MODE_FLASH2 = 3'd4,
    MODE_FLASH3 = 3'd5,
    MODE_DOUBLE = 3'd6
  } mode_t;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_BUTTON_SLOW  = 3'd0,
    REG_BUTTON_FAST  = 3'd1,
    REG_TOWER_SLOW   = 3'd2,
    REG_TOWER_FAST   = 3'd3,
    REG_DOUBLE_ON    = 3'd4,
    REG_DOUBLE_GAP   = 3'd5,
    REG_DOUBLE_PAUSE = 3'd6
  } reg_idx_t;

  localparam reg_t BUTTON_SLOW_RESET  = 16'd500;
  localparam reg_t BUTTON_FAST_RESET  = 16'd150;
  localparam reg_t TOWER_SLOW_RESET   = 16'd500;
  localparam reg_t TOWER_FAST_RESET   = 16'd250;
  localparam reg_t DOUBLE_ON_RESET    = 16'd180;
  localparam reg_t DOUBLE_GAP_RESET   = 16'd180;
  localparam reg_t DOUBLE_PAUSE_RESET = 16'd1000;

  localparam logic [1:0] FLASH2_COUNT = 2'd2;
  localparam logic [1:0] FLASH3_COUNT = 2'd3;

  typedef struct packed {
    reg_t button_slow;
    reg_t button_fast;
    reg_t tower_slow;
    reg_t tower_fast;
    reg_t double_on;
    reg_t double_gap;
    reg_t double_pause;
  } cfg_t;

  // one decoded command, already qualified by the pipeline advance
  typedef struct packed {
    logic       tick;
    logic       set_button;
    logic       set_tower;
    logic [1:0] button_index;
    logic [1:0] tower_color;
    logic [2:0] mode;
  } cmd_t;

  function automatic timer_t count_up(timer_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // zero interval never fires
  function automatic logic reached(timer_t e, reg_t interval);
    return (interval != '0) && (CMP_BITS'(e) >= CMP_BITS'(interval));
  endfunction

endpackage

`default_nettype wire

// ----- src/lbpg_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface lbpg_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [1:0] button_index;
  logic [1:0] tower_color;
  logic [2:0] led_mode;

  modport source (output valid, operation, button_index, tower_color, led_mode,
                  input ready);
  modport sink (input valid, operation, button_index, tower_color, led_mode,
                output ready);
endinterface

interface lbpg_lamps_if;
  logic                   valid;
  logic                   ready;
  lbpg_pkg::lamps_t       button_lamps;
  lbpg_pkg::lamps_t       tower_lamps;

  modport source (output valid, button_lamps, tower_lamps, input ready);
  modport sink (input valid, button_lamps, tower_lamps, output ready);
endinterface

interface lbpg_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [lbpg_pkg::REG_IDX_BITS-1:0]    index;
  lbpg_pkg::reg_t                       data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/led_blink_pattern_generator.sv -----
// LED blink pattern generator: three button lamps and a red/yellow/green tower lamp.
//
// Channels: cmd takes one beat per command (tick, set button, set tower);
// lamps returns exactly one beat per command with the lamp states after that
// command is applied; cfg writes the seven timing registers (index 0..6,
// other indexes are dropped) and is always ready.
//
// A cmd beat is captured in the input register; its lamps beat is driven from the
// result register. One command per cycle while lamps is not stalled. The path is an
// input register, the per-lamp next-state logic, then the result register; the next
// state of every lamp counter and flag is computed in one pass.
//
// Reset (rst, synchronous): all lamps off, modes off, counters cleared,
// timing registers back to their defaults, both pipeline registers empty.
//
// When the receiver stalls lamps, the result register holds and the input
// register still takes one more beat; cmd.ready drops only when both are full.
`timescale 1ns / 1ps
`default_nettype none

module led_blink_pattern_generator (
  input  wire logic     clk,
  input  wire logic     rst,
  lbpg_cmd_if.sink      cmd,
  lbpg_lamps_if.source  lamps,
  lbpg_cfg_if.sink      cfg
);

  lbpg_pkg::cfg_t regs;

  logic       in_full;
  logic [1:0] in_op;
  logic [1:0] in_bidx;
  logic [1:0] in_color;
  logic [2:0] in_mode;

  logic             out_valid;
  lbpg_pkg::lamps_t out_button;
  lbpg_pkg::lamps_t out_tower;

  logic           advance;
  logic           fire;
  lbpg_pkg::cmd_t step_cmd;

  logic [lbpg_pkg::NUM_BUTTONS-1:0] button_lit_after;
  lbpg_pkg::lamps_t                 button_bits;
  lbpg_pkg::lamps_t                 tower_bits;

  assign advance   = !out_valid || lamps.ready;
  assign fire      = in_full && advance;
  assign cmd.ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (cmd.ready) begin
      in_full <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_op    <= cmd.operation;
      in_bidx  <= cmd.button_index;
      in_color <= cmd.tower_color;
      in_mode  <= cmd.led_mode;
    end
  end

  always_comb begin
    step_cmd              = '0;
    step_cmd.button_index = in_bidx;
    step_cmd.tower_color  = in_color;
    step_cmd.mode         = in_mode;
    if (fire) begin
      case (in_op)
        lbpg_pkg::OP_TICK:       step_cmd.tick       = 1'b1;
        lbpg_pkg::OP_SET_BUTTON: step_cmd.set_button = 1'b1;
        lbpg_pkg::OP_SET_TOWER:  step_cmd.set_tower  = 1'b1;
        default: ;
      endcase
    end
  end

  lbpg_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  for (genvar i = 0; i < lbpg_pkg::NUM_BUTTONS; i++) begin : g_button
    lbpg_button u_button (
      .clk       (clk),
      .rst       (rst),
      .cmd       (step_cmd),
      .hit       (int'(in_bidx) == i + 1),
      .regs      (regs),
      .lit_after (button_lit_after[i])
    );
  end

  for (genvar i = 0; i < lbpg_pkg::LAMP_BITS; i++) begin : g_bits
    if (i < lbpg_pkg::NUM_BUTTONS) begin : g_used
      assign button_bits[i] = button_lit_after[i];
    end else begin : g_unused
      assign button_bits[i] = 1'b0;
    end
  end

  lbpg_tower u_tower (
    .clk         (clk),
    .rst         (rst),
    .cmd         (step_cmd),
    .regs        (regs),
    .lamps_after (tower_bits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_button <= button_bits;
      out_tower  <= tower_bits;
    end
  end

  assign lamps.valid        = out_valid;
  assign lamps.button_lamps = out_button;
  assign lamps.tower_lamps  = out_tower;

  a_tower_one_color: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0(out_tower))
    else $error("more than one tower lamp lit");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("processed command produced no result");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (in_full && out_valid && !lamps.ready) |-> !cmd.ready)
    else $error("command taken while both stages full");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !lamps.ready) |=> (out_valid && $stable(out_button) && $stable(out_tower)))
    else $error("result changed while stalled");

endmodule

`default_nettype wire

// ----- src/lbpg_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lbpg_cfg_regs (
  input  wire logic     clk,
  input  wire logic     rst,
  lbpg_cfg_if.sink      cfg,
  output lbpg_pkg::cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.button_slow  <= lbpg_pkg::BUTTON_SLOW_RESET;
      regs.button_fast  <= lbpg_pkg::BUTTON_FAST_RESET;
      regs.tower_slow   <= lbpg_pkg::TOWER_SLOW_RESET;
      regs.tower_fast   <= lbpg_pkg::TOWER_FAST_RESET;
      regs.double_on    <= lbpg_pkg::DOUBLE_ON_RESET;
      regs.double_gap   <= lbpg_pkg::DOUBLE_GAP_RESET;
      regs.double_pause <= lbpg_pkg::DOUBLE_PAUSE_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        lbpg_pkg::REG_BUTTON_SLOW:  regs.button_slow  <= cfg.data;
        lbpg_pkg::REG_BUTTON_FAST:  regs.button_fast  <= cfg.data;
        lbpg_pkg::REG_TOWER_SLOW:   regs.tower_slow   <= cfg.data;
        lbpg_pkg::REG_TOWER_FAST:   regs.tower_fast   <= cfg.data;
        lbpg_pkg::REG_DOUBLE_ON:    regs.double_on    <= cfg.data;
        lbpg_pkg::REG_DOUBLE_GAP:   regs.double_gap   <= cfg.data;
        lbpg_pkg::REG_DOUBLE_PAUSE: regs.double_pause <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/lbpg_button.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lbpg_button (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire lbpg_pkg::cmd_t cmd,
  input  wire logic           hit,
  input  wire lbpg_pkg::cfg_t regs,
  output logic                lit_after
);

  logic [2:0]       mode, mode_next;
  logic             lit, lit_next;
  lbpg_pkg::timer_t elapsed, elapsed_next;
  logic [1:0]       flashes, flashes_next;

  logic             flash;
  lbpg_pkg::reg_t   interval;
  lbpg_pkg::timer_t counted;

  always_comb begin
    flash    = (mode == lbpg_pkg::MODE_FLASH2) || (mode == lbpg_pkg::MODE_FLASH3);
    interval = '0;
    if (mode == lbpg_pkg::MODE_FAST || flash) begin
      interval = regs.button_fast;
    end else if (mode == lbpg_pkg::MODE_SLOW) begin
      interval = regs.button_slow;
    end
    counted = lbpg_pkg::count_up(elapsed);
  end

  always_comb begin
    mode_next    = mode;
    lit_next     = lit;
    elapsed_next = elapsed;
    flashes_next = flashes;
    if (cmd.tick) begin
      elapsed_next = counted;
      if (lbpg_pkg::reached(counted, interval)) begin
        elapsed_next = '0;
        if (flash && lit) begin
          // pulse ends with the lamp off; the last pulse drops the mode back to off
          lit_next = 1'b0;
          if (flashes != '0) begin
            flashes_next = flashes - 1'b1;
          end
          if (flashes <= 2'd1) begin
            mode_next = lbpg_pkg::MODE_OFF;
          end
        end else begin
          lit_next = !lit;
        end
      end
    end else if (cmd.set_button && hit) begin
      mode_next    = cmd.mode;
      lit_next     = (cmd.mode != lbpg_pkg::MODE_OFF);
      elapsed_next = '0;
      case (cmd.mode)
        lbpg_pkg::MODE_FLASH2: flashes_next = lbpg_pkg::FLASH2_COUNT;
        lbpg_pkg::MODE_FLASH3: flashes_next = lbpg_pkg::FLASH3_COUNT;
        default:               flashes_next = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= lbpg_pkg::MODE_OFF;
      lit     <= 1'b0;
      elapsed <= '0;
      flashes <= '0;
    end else begin
      mode    <= mode_next;
      lit     <= lit_next;
      elapsed <= elapsed_next;
      flashes <= flashes_next;
    end
  end

  assign lit_after = lit_next;

endmodule

`default_nettype wire

// ----- src/lbpg_tower.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lbpg_tower (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire lbpg_pkg::cmd_t cmd,
  input  wire lbpg_pkg::cfg_t regs,
  output lbpg_pkg::lamps_t    lamps_after
);

  logic [1:0]       selected, selected_next;
  logic [2:0]       mode, mode_next;
  logic             lit, lit_next;
  logic [1:0]       step, step_next;
  lbpg_pkg::timer_t elapsed, elapsed_next;

  lbpg_pkg::reg_t   interval;
  lbpg_pkg::timer_t counted;
  logic [1:0]       step_inc;

  always_comb begin
    case (mode)
      lbpg_pkg::MODE_FAST: interval = regs.tower_fast;
      lbpg_pkg::MODE_SLOW: interval = regs.tower_slow;
      lbpg_pkg::MODE_DOUBLE: begin
        // steps: on, gap, on, pause
        case (step)
          2'd1:    interval = regs.double_gap;
          2'd3:    interval = regs.double_pause;
          default: interval = regs.double_on;
        endcase
      end
      default: interval = '0;
    endcase
    counted  = lbpg_pkg::count_up(elapsed);
    step_inc = step + 2'd1;
  end

  always_comb begin
    selected_next = selected;
    mode_next     = mode;
    lit_next      = lit;
    step_next     = step;
    elapsed_next  = elapsed;
    if (cmd.tick) begin
      elapsed_next = counted;
      if (lbpg_pkg::reached(counted, interval)) begin
        elapsed_next = '0;
        if (mode == lbpg_pkg::MODE_DOUBLE) begin
          step_next = step_inc;
          lit_next  = !step_inc[0];
        end else begin
          lit_next = !lit;
        end
      end
    end else if (cmd.set_tower) begin
      selected_next = cmd.tower_color;
      mode_next     = cmd.mode;
      lit_next      = (cmd.mode != lbpg_pkg::MODE_OFF) && (cmd.tower_color != '0);
      step_next     = '0;
      elapsed_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      selected <= '0;
      mode     <= lbpg_pkg::MODE_OFF;
      lit      <= 1'b0;
      step     <= '0;
      elapsed  <= '0;
    end else begin
      selected <= selected_next;
      mode     <= mode_next;
      lit      <= lit_next;
      step     <= step_next;
      elapsed  <= elapsed_next;
    end
  end

  // colour 0 keeps every lamp dark
  always_comb begin
    lamps_after = '0;
    if (lit_next && selected_next != '0) begin
      lamps_after = lbpg_pkg::lamps_t'(1) << (selected_next - 2'd1);
    end
  end

endmodule

`default_nettype wire
